/* src/tss_pkg.sv */
package tss_pkg;

	localparam int COLOR_BITS = 16;

	localparam int EDGE_LANES = 2;
	localparam int LANE_LONG  = 0;
	localparam int LANE_SHORT = 1;

	typedef logic [COLOR_BITS-1:0] color_t;

	typedef struct packed {
		logic en;
		logic valid;
	} stage_ctl_t;

endpackage

/* src/tss_div.sv */
module tss_div #(
	parameter int W      = 11,
	parameter int LANES  = 2,
	parameter int SIDE_W = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tss_pkg::stage_ctl_t    ctl,
	input  logic [2*W-1:0]         num [LANES],
	input  logic [W-1:0]           den [LANES],
	input  logic [SIDE_W-1:0]      side_in,
	output logic [W-1:0]           quo [LANES],
	output logic [SIDE_W-1:0]      side_out,
	output logic                   valid
);

	// one restoring step per stage; quotient bits shift in below the dividend
	logic              v_s    [W];
	logic [SIDE_W-1:0] side_s [W];
	logic [W-1:0]      rem_s  [LANES][W];
	logic [W-1:0]      lo_s   [LANES][W];
	logic [W-1:0]      den_s  [LANES][W];

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic              pv;
		logic [SIDE_W-1:0] pside;

		if (k == 0) begin : g_first
			assign pv    = ctl.valid;
			assign pside = side_in;
		end else begin : g_next
			assign pv    = v_s[k-1];
			assign pside = side_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (ctl.en) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				side_s[k] <= pside;
			end
		end

		for (genvar g = 0; g < LANES; g++) begin : g_lane
			logic [W-1:0] pr;
			logic [W-1:0] plo;
			logic [W-1:0] pd;
			logic [W:0]   r2;
			logic [W:0]   diff;
			logic         ge;

			if (k == 0) begin : g_first
				assign pr  = num[g][2*W-1:W];
				assign plo = num[g][W-1:0];
				assign pd  = den[g];
			end else begin : g_next
				assign pr  = rem_s[g][k-1];
				assign plo = lo_s[g][k-1];
				assign pd  = den_s[g][k-1];
			end

			assign r2   = {pr, plo[W-1]};
			assign ge   = r2 >= {1'b0, pd};
			assign diff = r2 - {1'b0, pd};

			always_ff @(posedge clk) begin
				if (ctl.en) begin
					rem_s[g][k] <= ge ? diff[W-1:0] : r2[W-1:0];
					lo_s[g][k]  <= {plo[W-2:0], ge};
					den_s[g][k] <= pd;
				end
			end
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_quo
		assign quo[g] = lo_s[g][W-1];
	end

	assign valid    = v_s[W-1];
	assign side_out = side_s[W-1];

endmodule

/* src/triangle_scanline_span_top.sv */
// Span of a filled triangle on one scanline. Each word carries three vertices, a query row
// and a fill colour; the vertices are sorted by y, the long edge (lowest to highest vertex)
// and the short edge that holds the row are interpolated exactly in integers, truncated
// toward zero, and the two ends give span_left and span_width. A row outside the triangle
// gives row_covered low with all other fields zero. A new word is taken every cycle while
// the output skid register is empty. The edge divider resolves one quotient bit per
// pipeline stage. A skid register at the output lets the pipeline take one more word
// while a result waits.
module triangle_scanline_span_top #(
	parameter int COORD_BITS = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_BITS-1:0]  ax,
	input  logic signed [COORD_BITS-1:0]  ay,
	input  logic signed [COORD_BITS-1:0]  bx,
	input  logic signed [COORD_BITS-1:0]  by,
	input  logic signed [COORD_BITS-1:0]  cx,
	input  logic signed [COORD_BITS-1:0]  cy,
	input  logic signed [COORD_BITS-1:0]  query_row,
	input  tss_pkg::color_t               fill_color,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          row_covered,
	output logic signed [COORD_BITS-1:0]  span_left,
	output logic [COORD_BITS:0]           span_width,
	output tss_pkg::color_t               span_color
);

	localparam int W      = COORD_BITS;
	localparam int CW     = tss_pkg::COLOR_BITS;
	localparam int L      = tss_pkg::EDGE_LANES;
	localparam int LL     = tss_pkg::LANE_LONG;
	localparam int LS     = tss_pkg::LANE_SHORT;
	localparam int EDGE_W = 2*W + 2;
	localparam int SIDE_W = 1 + CW + L*EDGE_W;

	logic en;
	logic sk_v_q;

	assign en       = !sk_v_q;
	assign in_ready = en;

	// sort by y
	logic signed [W-1:0] px0, py0, px1, py1, px2, py2;
	logic signed [W-1:0] rx0, ry0, rx1, ry1, rx2, ry2;
	logic signed [W-1:0] fx0, fy0, fx1, fy1, fx2, fy2;

	always_comb begin
		if (ay > by) begin
			{px0, py0, px1, py1} = {bx, by, ax, ay};
		end else begin
			{px0, py0, px1, py1} = {ax, ay, bx, by};
		end
		px2 = cx;
		py2 = cy;
		if (py1 > py2) begin
			{rx1, ry1, rx2, ry2} = {px2, py2, px1, py1};
		end else begin
			{rx1, ry1, rx2, ry2} = {px1, py1, px2, py2};
		end
		rx0 = px0;
		ry0 = py0;
		if (ry0 > ry1) begin
			{fx0, fy0, fx1, fy1} = {rx1, ry1, rx0, ry0};
		end else begin
			{fx0, fy0, fx1, fy1} = {rx0, ry0, rx1, ry1};
		end
		fx2 = rx2;
		fy2 = ry2;
	end

	logic                v_s1;
	logic signed [W-1:0] x0_s1, y0_s1, x1_s1, y1_s1, x2_s1, y2_s1, q_s1;
	tss_pkg::color_t     col_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x0_s1  <= fx0;
			y0_s1  <= fy0;
			x1_s1  <= fx1;
			y1_s1  <= fy1;
			x2_s1  <= fx2;
			y2_s1  <= fy2;
			q_s1   <= query_row;
			col_s1 <= fill_color;
		end
	end

	// edge setup
	logic                cov2;
	logic                upper2;
	logic signed [W-1:0] e_xs [L];
	logic signed [W-1:0] e_ys [L];
	logic signed [W-1:0] e_xe [L];
	logic signed [W-1:0] e_ye [L];

	assign cov2   = (q_s1 >= y0_s1) && (q_s1 <= y2_s1);
	assign upper2 = q_s1 <= y1_s1;

	always_comb begin
		e_xs[LL] = x0_s1;
		e_ys[LL] = y0_s1;
		e_xe[LL] = x2_s1;
		e_ye[LL] = y2_s1;
		if (upper2) begin
			e_xs[LS] = x0_s1;
			e_ys[LS] = y0_s1;
			e_xe[LS] = x1_s1;
			e_ye[LS] = y1_s1;
		end else begin
			e_xs[LS] = x1_s1;
			e_ys[LS] = y1_s1;
			e_xe[LS] = x2_s1;
			e_ye[LS] = y2_s1;
		end
	end

	logic                v_s2;
	logic                cov_s2;
	tss_pkg::color_t     col_s2;
	logic [W-1:0]        adx_s2  [L];
	logic [W-1:0]        dq_s2   [L];
	logic [W-1:0]        dy_s2   [L];
	logic                neg_s2  [L];
	logic                flat_s2 [L];
	logic signed [W-1:0] xs_s2   [L];
	logic signed [W-1:0] xe_s2   [L];

	logic                v_s3;
	logic [2*W-1:0]      mag_s3  [L];
	logic [W-1:0]        den_s3  [L];
	logic [SIDE_W-1:0]   side_s3;

	for (genvar g = 0; g < L; g++) begin : g_edge
		logic signed [W:0] dx;
		logic signed [W:0] dy;
		logic signed [W:0] dq;
		logic signed [W:0] adx;

		assign dx  = $signed({e_xe[g][W-1], e_xe[g]}) - $signed({e_xs[g][W-1], e_xs[g]});
		assign dy  = $signed({e_ye[g][W-1], e_ye[g]}) - $signed({e_ys[g][W-1], e_ys[g]});
		assign dq  = $signed({q_s1[W-1], q_s1}) - $signed({e_ys[g][W-1], e_ys[g]});
		assign adx = dx[W] ? -dx : dx;

		always_ff @(posedge clk) begin
			if (en) begin
				adx_s2[g]  <= adx[W-1:0];
				dq_s2[g]   <= dq[W-1:0];
				dy_s2[g]   <= dy[W-1:0];
				neg_s2[g]  <= dx[W];
				flat_s2[g] <= dy == '0;
				xs_s2[g]   <= e_xs[g];
				xe_s2[g]   <= e_xe[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mag_s3[g] <= {{W{1'b0}}, adx_s2[g]} * {{W{1'b0}}, dq_s2[g]};
				den_s3[g] <= dy_s2[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cov_s2  <= cov2;
			col_s2  <= col_s1;
			side_s3 <= {cov_s2, col_s2,
				xs_s2[LL], xe_s2[LL], neg_s2[LL], flat_s2[LL],
				xs_s2[LS], xe_s2[LS], neg_s2[LS], flat_s2[LS]};
		end
	end

	// pipelined division of both edges
	tss_pkg::stage_ctl_t div_ctl;
	logic [W-1:0]        quo_d [L];
	logic [SIDE_W-1:0]   side_d;
	logic                v_d;

	assign div_ctl.en    = en;
	assign div_ctl.valid = v_s3;

	tss_div #(
		.W      (W),
		.LANES  (L),
		.SIDE_W (SIDE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.num      (mag_s3),
		.den      (den_s3),
		.side_in  (side_s3),
		.quo      (quo_d),
		.side_out (side_d),
		.valid    (v_d)
	);

	logic                cov_d;
	tss_pkg::color_t     col_d;
	logic signed [W-1:0] xs_d   [L];
	logic signed [W-1:0] xe_d   [L];
	logic                neg_d  [L];
	logic                flat_d [L];
	logic signed [W-1:0] x_d    [L];

	assign {cov_d, col_d,
		xs_d[LL], xe_d[LL], neg_d[LL], flat_d[LL],
		xs_d[LS], xe_d[LS], neg_d[LS], flat_d[LS]} = side_d;

	for (genvar g = 0; g < L; g++) begin : g_end
		logic signed [W:0] xsx;
		logic signed [W:0] qv;
		logic signed [W:0] sum;

		assign xsx    = $signed({xs_d[g][W-1], xs_d[g]});
		assign qv     = $signed({1'b0, quo_d[g]});
		assign sum    = neg_d[g] ? xsx - qv : xsx + qv;
		assign x_d[g] = flat_d[g] ? xe_d[g] : sum[W-1:0];
	end

	logic                v_s4;
	logic                cov_s4;
	tss_pkg::color_t     col_s4;
	logic signed [W-1:0] xa_s4;
	logic signed [W-1:0] xb_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			cov_s4 <= cov_d;
			col_s4 <= col_d;
			xa_s4  <= x_d[LL];
			xb_s4  <= x_d[LS];
		end
	end

	// order the ends
	logic signed [W-1:0] lo5;
	logic signed [W-1:0] hi5;
	logic [W:0]          wd5;

	assign lo5 = (xa_s4 > xb_s4) ? xb_s4 : xa_s4;
	assign hi5 = (xa_s4 > xb_s4) ? xa_s4 : xb_s4;
	assign wd5 = $unsigned($signed({hi5[W-1], hi5}) - $signed({lo5[W-1], lo5}))
		+ (W+1)'(1);

	logic                v_s5;
	logic                cov_s5;
	logic signed [W-1:0] left_s5;
	logic [W:0]          width_s5;
	tss_pkg::color_t     col_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_d;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cov_s5   <= cov_s4;
			left_s5  <= cov_s4 ? lo5 : '0;
			width_s5 <= cov_s4 ? wd5 : '0;
			col_s5   <= cov_s4 ? col_s4 : '0;
		end
	end

	// output skid
	logic                sk_cov_q;
	logic signed [W-1:0] sk_left_q;
	logic [W:0]          sk_width_q;
	tss_pkg::color_t     sk_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sk_v_q <= 1'b0;
		end else if (sk_v_q) begin
			if (out_ready) begin
				sk_v_q <= 1'b0;
			end
		end else if (v_s5 && !out_ready) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!sk_v_q) begin
			sk_cov_q   <= cov_s5;
			sk_left_q  <= left_s5;
			sk_width_q <= width_s5;
			sk_col_q   <= col_s5;
		end
	end

	assign out_valid   = sk_v_q || v_s5;
	assign row_covered = sk_v_q ? sk_cov_q   : cov_s5;
	assign span_left   = sk_v_q ? sk_left_q  : left_s5;
	assign span_width  = sk_v_q ? sk_width_q : width_s5;
	assign span_color  = sk_v_q ? sk_col_q   : col_s5;

	a_uncovered_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !row_covered |-> span_left == '0 && span_width == '0 && span_color == '0)
		else $error("uncovered row with non-zero span");

	a_covered_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && row_covered |-> span_width != '0)
		else $error("covered row with empty span");

	a_skid_capture: assert property (@(posedge clk) disable iff (!arst_n)
		!sk_v_q && v_s5 && !out_ready |=> sk_v_q)
		else $error("stalled word not held in skid");

	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |=> $stable(v_s5) && $stable(left_s5) && $stable(width_s5))
		else $error("pipeline moved while skid full");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam int CB           = 11;
	localparam int N_DIR        = 18;
	localparam int N_RAND       = 880;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 3 * (CB + 5);
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		logic [CB-1:0]   ax;
		logic [CB-1:0]   ay;
		logic [CB-1:0]   bx;
		logic [CB-1:0]   by;
		logic [CB-1:0]   cx;
		logic [CB-1:0]   cy;
		logic [CB-1:0]   qrow;
		tss_pkg::color_t color;
	} span_query_t;

	typedef struct packed {
		logic            covered;
		logic [CB-1:0]   left;
		logic [CB:0]     width;
		tss_pkg::color_t color;
	} span_t;

	typedef struct {
		int ax, ay, bx, by, cx, cy, row, color;
		bit typed;
		int cov, left, width;
	} dir_row_t;

	// ax ay bx by cx cy row colour | typed covered left width
	dir_row_t dir_tbl [N_DIR] = '{
		'{0, 0, 0, 0, 0, 0, 0, 'h1234, 1, 1, 0, 1},
		'{-1024, -1024, 1023, -1024, -1024, 1023, -1024, 'hFFFF, 1, 1, -1024, 2048},
		'{-1024, -1024, 1023, -1024, -1024, 1023, 1023, 'h0000, 1, 1, -1024, 1},
		'{-1024, -1024, 1023, -1024, -1024, 1023, 0, 'h5555, 0, 0, 0, 0},
		'{0, -5, 10, 5, -10, 3, -6, 'hBEEF, 1, 0, 0, 0},
		'{0, -5, 10, 5, -10, 3, 6, 'hBEEF, 1, 0, 0, 0},
		'{0, -5, 10, 5, -10, 3, -5, 'h0F0F, 0, 0, 0, 0},
		'{0, -5, 10, 5, -10, 3, 3, 'hF0F0, 0, 0, 0, 0},
		'{0, -5, 10, 5, -10, 3, 4, 'h7BEF, 0, 0, 0, 0},
		'{0, 1023, 1, 1023, 2, 1022, -1024, 'hFFFF, 1, 0, 0, 0},
		'{7, -1024, -7, -1024, 0, -1024, 1023, 'h8000, 1, 0, 0, 0},
		'{5, 7, -3, 7, 9, 7, 7, 'hA5A5, 1, 1, -3, 13},
		'{30, 20, 10, 10, 0, 0, 5, 'h07E0, 0, 0, 0, 0},
		'{10, 10, 0, 0, 30, 20, 15, 'hF800, 0, 0, 0, 0},
		'{4, 3, 8, 3, 0, 9, 3, 'h001F, 0, 0, 0, 0},
		'{0, 0, -5, 3, 5, 3, 1, 'h1111, 0, 0, 0, 0},
		'{1023, 0, -1024, 0, 0, 0, 0, 'h2222, 0, 0, 0, 0},
		'{-1024, 1023, 1023, -1024, 0, 0, -1, 'h3333, 0, 0, 0, 0}
	};

	logic            clk = 1'b0;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	logic [CB-1:0]   ax, ay, bx, by, cx, cy, query_row;
	tss_pkg::color_t fill_color;
	logic            out_valid;
	logic            out_ready;
	logic            row_covered;
	logic [CB-1:0]   span_left;
	logic [CB:0]     span_width;
	tss_pkg::color_t span_color;

	span_t span_q [$];
	int    idle_pct   = 10;
	bit    hold_req   = 1'b0;
	int    err_cnt    = 0;
	int    n_sent     = 0;
	int    n_spans    = 0;
	int    n_covered  = 0;
	int    n_cycles   = 0;

	triangle_scanline_span_top #(
		.COORD_BITS(CB)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.ax         (ax),
		.ay         (ay),
		.bx         (bx),
		.by         (by),
		.cx         (cx),
		.cy         (cy),
		.query_row  (query_row),
		.fill_color (fill_color),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.row_covered(row_covered),
		.span_left  (span_left),
		.span_width (span_width),
		.span_color (span_color)
	);

	always #4 clk = ~clk;

	function automatic int edge_x_at(int xs, int ys, int xe, int ye, int r);
		if (ye == ys)
			return xe;
		return xs + ((xe - xs) * (r - ys)) / (ye - ys);
	endfunction

	function automatic span_t predict_span(span_query_t q);
		int    x0, y0, x1, y1, x2, y2, r, t, xl, xr, w;
		span_t s;
		x0 = $signed(q.ax);
		y0 = $signed(q.ay);
		x1 = $signed(q.bx);
		y1 = $signed(q.by);
		x2 = $signed(q.cx);
		y2 = $signed(q.cy);
		r  = $signed(q.qrow);
		if (y0 > y1) begin
			t = y0; y0 = y1; y1 = t;
			t = x0; x0 = x1; x1 = t;
		end
		if (y1 > y2) begin
			t = y1; y1 = y2; y2 = t;
			t = x1; x1 = x2; x2 = t;
		end
		if (y0 > y1) begin
			t = y0; y0 = y1; y1 = t;
			t = x0; x0 = x1; x1 = t;
		end
		s = '0;
		if (r < y0 || r > y2)
			return s;
		xl = edge_x_at(x0, y0, x2, y2, r);
		xr = (r <= y1) ? edge_x_at(x0, y0, x1, y1, r) : edge_x_at(x1, y1, x2, y2, r);
		if (xl > xr) begin
			t = xl; xl = xr; xr = t;
		end
		w = xr - xl + 1;
		s.covered = 1'b1;
		s.left    = xl[CB-1:0];
		s.width   = w[CB:0];
		s.color   = q.color;
		return s;
	endfunction

	function automatic span_query_t rand_query();
		span_query_t q;
		int          mode, lo, hi, bxp, byp, ya, yb, yc;
		q.ax    = CB'($urandom);
		q.ay    = CB'($urandom);
		q.bx    = CB'($urandom);
		q.by    = CB'($urandom);
		q.cx    = CB'($urandom);
		q.cy    = CB'($urandom);
		q.qrow  = CB'($urandom);
		q.color = tss_pkg::color_t'($urandom_range(0, 65535));
		mode    = $urandom_range(0, 9);
		if (mode == 8) begin
			// small triangle, row near it
			bxp    = $urandom_range(0, 2027) - 1014;
			byp    = $urandom_range(0, 2027) - 1014;
			q.ax   = CB'(bxp + $urandom_range(0, 16) - 8);
			q.bx   = CB'(bxp + $urandom_range(0, 16) - 8);
			q.cx   = CB'(bxp + $urandom_range(0, 16) - 8);
			q.ay   = CB'(byp + $urandom_range(0, 16) - 8);
			q.by   = CB'(byp + $urandom_range(0, 16) - 8);
			q.cy   = CB'(byp + $urandom_range(0, 16) - 8);
			q.qrow = CB'(byp + $urandom_range(0, 20) - 10);
		end else if (mode >= 2) begin
			if (mode == 9) begin
				// ties in y
				q.by = q.ay;
				if ($urandom_range(0, 1))
					q.cy = q.ay;
			end
			ya = $signed(q.ay);
			yb = $signed(q.by);
			yc = $signed(q.cy);
			lo = (ya < yb) ? ya : yb;
			lo = (yc < lo) ? yc : lo;
			hi = (ya > yb) ? ya : yb;
			hi = (yc > hi) ? yc : hi;
			case ($urandom_range(0, 7))
				0:       q.qrow = q.ay;
				1:       q.qrow = q.by;
				2:       q.qrow = q.cy;
				default: q.qrow = CB'(lo + $urandom_range(0, hi - lo));
			endcase
		end
		return q;
	endfunction

	task automatic idle_sender(int n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_query(span_query_t q, span_t want);
		@(negedge clk);
		ax         <= q.ax;
		ay         <= q.ay;
		bx         <= q.bx;
		by         <= q.by;
		cx         <= q.cx;
		cy         <= q.cy;
		query_row  <= q.qrow;
		fill_color <= q.color;
		in_valid   <= 1'b1;
		do @(posedge clk); while (!in_ready);
		span_q.push_back(want);
		n_sent++;
	endtask

	// stimulus
	initial begin
		dir_row_t    r;
		span_query_t q;
		span_t       want;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		ax         = '0;
		ay         = '0;
		bx         = '0;
		by         = '0;
		cx         = '0;
		cy         = '0;
		query_row  = '0;
		fill_color = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tbl[i]) begin
			r       = dir_tbl[i];
			q.ax    = CB'(r.ax);
			q.ay    = CB'(r.ay);
			q.bx    = CB'(r.bx);
			q.by    = CB'(r.by);
			q.cx    = CB'(r.cx);
			q.cy    = CB'(r.cy);
			q.qrow  = CB'(r.row);
			q.color = tss_pkg::color_t'(r.color);
			if (r.typed) begin
				want.covered = r.cov[0];
				want.left    = CB'(r.left);
				want.width   = (CB + 1)'(r.width);
				want.color   = r.cov[0] ? q.color : '0;
			end else begin
				want = predict_span(q);
			end
			if ($urandom_range(0, 99) < idle_pct)
				idle_sender($urandom_range(1, 6));
			send_query(q, want);
		end

		for (int i = 0; i < N_RAND; i++) begin
			case (i)
				0:            idle_pct = 0;
				30:           hold_req = 1'b1;
				200:          idle_pct = 15;
				400:          idle_pct = 40;
				600:          idle_pct = 10;
				N_RAND - 100: idle_pct = 0;
				default: ;
			endcase
			if (i == 450) begin
				// let the pipeline run dry
				idle_sender(1);
				wait (span_q.size() == 0);
			end
			if ($urandom_range(0, 99) < idle_pct)
				idle_sender($urandom_range(1, 6));
			q = rand_query();
			send_query(q, predict_span(q));
		end

		@(negedge clk);
		in_valid <= 1'b0;
		wait (span_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d triangle/row words sent (%0d directed), %0d spans checked, %0d covered",
			n_sent, N_DIR, n_spans, n_covered);
		$display("with output hold-off, drained pause and random idling on both sides");
		if (err_cnt == 0 && span_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// sink
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if ($urandom_range(0, 99) < idle_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		span_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {row_covered, span_left, span_width, span_color};
			n_spans++;
			if (got.covered)
				n_covered++;
			if (span_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected span: cov=%0b left=%0d width=%0d colour=%h",
						got.covered, $signed(got.left), got.width, got.color);
			end else begin
				want = span_q.pop_front();
				if (got !== want) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("span mismatch: want cov=%0b left=%0d width=%0d colour=%h, got cov=%0b left=%0d width=%0d colour=%h",
							want.covered, $signed(want.left), want.width, want.color,
							got.covered, $signed(got.left), got.width, got.color);
				end
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", n_cycles);
			$display("FAILURE");
			$finish;
		end
	end

endmodule
